// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: shared constants, types and helpers of the periodic tick scheduler
// Slot table size, field widths, opcodes and the command word that the
// front end hands to the execution engine.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int SLOTS       = 32;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_OUT     = 32;
    localparam int NCNT_W      = $clog2(MAX_OUT + 1);
    localparam int MS_TO_US    = 1000;
    localparam int OP_W        = 2;
    localparam int PMS_W       = 22;
    localparam int TIME_W      = 32;
    localparam int SLOT_IN_W   = 5;
    localparam int PERIOD_W    = 31;
    localparam int PROD_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_HANDLE = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_HANDLE,
        KIND_REPORT,
        KIND_NONE
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [PERIOD_W-1:0]   period_us;
        logic [TIME_W-1:0]     now_us;
        logic [SLOT_IN_W-1:0]  slot;
        logic                  slot_in_range;
        logic                  keep;
    } cmd_t;

    // low five bits of a table index, as carried on the result channel
    function automatic logic [SLOT_IN_W-1:0] slot_code(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+SLOT_IN_W-1:0] wide;
        wide = {{SLOT_IN_W{1'b0}}, idx};
        return wide[SLOT_IN_W-1:0];
    endfunction

    // table index named by a reported slot number
    function automatic logic [SLOT_W-1:0] slot_index(input logic [SLOT_IN_W-1:0] s);
        logic [SLOT_W+SLOT_IN_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, s};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/pts_if.sv =====
// ----------------------------------------------------------------------------
// pts_if: channel interfaces of the periodic tick scheduler
// Command channel into the block and event channel out of it, both
// valid/ready with source and sink modports.
// ----------------------------------------------------------------------------
interface pts_cmd_if;
    import pts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [PMS_W-1:0]      period_ms;
    logic [TIME_W-1:0]     now_us;
    logic [SLOT_IN_W-1:0]  slot;
    logic                  keep;

    modport source (output valid, op, period_ms, now_us, slot, keep, input ready);
    modport sink   (input valid, op, period_ms, now_us, slot, keep, output ready);
endinterface

interface pts_evt_if;
    import pts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic [SLOT_IN_W-1:0]  slot_out;
    logic                  last;

    modport source (output valid, ok, slot_out, last, input ready);
    modport sink   (input valid, ok, slot_out, last, output ready);
endinterface

// ===== rtl/pts_ram.sv =====
// ----------------------------------------------------------------------------
// pts_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pts_front.sv =====
// ----------------------------------------------------------------------------
// pts_front: command intake and classification
// Registers each command transaction, decodes the opcode, range-checks the
// slot and converts the period to saturated microseconds.
// ----------------------------------------------------------------------------
module pts_front (
    input  logic           clk,
    input  logic           rst_n,
    pts_cmd_if.sink        cmd,
    output logic           push_valid,
    input  logic           push_ready,
    output pts_pkg::cmd_t  push_data
);
    import pts_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [PMS_W-1:0]      period_ms;
        logic [TIME_W-1:0]     now_us;
        logic [SLOT_IN_W-1:0]  slot;
        logic                  keep;
    } raw_t;

    logic              stage_valid_reg;
    logic              stage_valid_next;
    raw_t              stage_reg;
    raw_t              stage_next;
    logic              accept;
    logic [PROD_W-1:0] prod;

    assign cmd.ready = !stage_valid_reg || push_ready;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
            stage_next       = '{op: cmd.op, period_ms: cmd.period_ms, now_us: cmd.now_us,
                                 slot: cmd.slot, keep: cmd.keep};
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            stage_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            stage_reg       <= stage_next;
        end
    end

    // 22 x 10 bit product fits in 32 bits; top bit set means over 2^31-1
    assign prod = PROD_W'(stage_reg.period_ms) * PROD_W'(MS_TO_US);

    always_comb
    begin
        push_data.period_us     = prod[PROD_W-1] ? {PERIOD_W{1'b1}} : prod[PERIOD_W-1:0];
        push_data.now_us        = stage_reg.now_us;
        push_data.slot          = stage_reg.slot;
        push_data.keep          = stage_reg.keep;
        push_data.slot_in_range = (32'(stage_reg.slot) < 32'(SLOTS));
        unique case (stage_reg.op)
            OP_ADD:    push_data.kind = KIND_ADD;
            OP_HANDLE: push_data.kind = KIND_HANDLE;
            OP_REPORT: push_data.kind = KIND_REPORT;
            default:   push_data.kind = KIND_NONE;
        endcase
    end

    assign push_valid = stage_valid_reg;

endmodule

// ===== rtl/pts_queue.sv =====
// ----------------------------------------------------------------------------
// pts_queue: command queue between front end and engine
// Small register FIFO so that intake and execution stall independently.
// ----------------------------------------------------------------------------
module pts_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  pts_pkg::cmd_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output pts_pkg::cmd_t  pop_data
);
    import pts_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg;
    logic [QW-1:0] wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg;
    logic [QW-1:0] rd_ptr_next;
    logic [QC-1:0] count_reg;
    logic [QC-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != QC'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/pts_engine.sv =====
// ----------------------------------------------------------------------------
// pts_engine: slot table and command execution
// Holds the armed/pending bits and the deadline and period RAMs, runs the
// free-slot scan for add, the earliest-deadline passes for handle and the
// re-arm for report with keep, and drives the event output register.
// ----------------------------------------------------------------------------
module pts_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  pts_pkg::cmd_t  pop_data,
    pts_evt_if.source      evt
);
    import pts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_HND_SCAN,
        S_HND_FLUSH,
        S_REP_READ,
        S_POST
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    state_t                state_reg, state_next;
    state_t                ret_reg, ret_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [SLOTS-1:0]      armed_reg, armed_next;
    logic [SLOTS-1:0]      pending_reg, pending_next;
    logic [TIME_W-1:0]     handle_time_reg, handle_time_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic                  iss_done_reg, iss_done_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                  best_found_reg, best_found_next;
    logic [SLOT_W-1:0]     best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]     best_dl_reg, best_dl_next;
    logic                  held_valid_reg, held_valid_next;
    logic [SLOT_W-1:0]     held_idx_reg, held_idx_next;
    logic [NCNT_W-1:0]     n_reg, n_next;
    logic                  res_ok_reg, res_ok_next;
    logic [SLOT_IN_W-1:0]  res_slot_reg, res_slot_next;
    logic                  res_last_reg, res_last_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_ok_reg, out_ok_next;
    logic [SLOT_IN_W-1:0]  out_slot_reg, out_slot_next;
    logic                  out_last_reg, out_last_next;

    logic                  dl_we;
    logic [SLOT_W-1:0]     dl_waddr;
    logic [TIME_W-1:0]     dl_wdata;
    logic [TIME_W-1:0]     dl_rdata;
    logic                  pr_we;
    logic [PERIOD_W-1:0]   pr_rdata;

    logic                  out_free;
    logic                  due;
    logic                  cand;
    logic                  f_found;
    logic [SLOT_W-1:0]     f_idx;
    logic [TIME_W-1:0]     f_dl;
    logic [NCNT_W-1:0]     n_inc;
    logic [SLOT_W-1:0]     rep_idx;
    logic [SLOT_W-1:0]     pop_idx;

    pts_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_deadline_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (idx_reg),
        .rdata (dl_rdata)
    );

    pts_ram #(.WIDTH(PERIOD_W), .DEPTH(SLOTS)) u_period_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (idx_reg),
        .wdata (cmd_reg.period_us),
        .raddr (pop_idx),
        .rdata (pr_rdata)
    );

    assign pop_idx   = slot_index(pop_data.slot);
    assign rep_idx   = slot_index(cmd_reg.slot);
    assign pop_ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || evt.ready;

    assign evt.valid    = out_valid_reg;
    assign evt.ok       = out_ok_reg;
    assign evt.slot_out = out_slot_reg;
    assign evt.last     = out_last_reg;

    // deadline at chk_idx_reg: due when time is past it as signed values
    assign due     = ($signed(cmd_reg.now_us) > $signed(dl_rdata));
    assign cand    = chk_valid_reg && armed_reg[chk_idx_reg] && due
                     && (!best_found_reg || (dl_rdata < best_dl_reg));
    assign f_found = best_found_reg || cand;
    assign f_idx   = cand ? chk_idx_reg : best_idx_reg;
    assign f_dl    = cand ? dl_rdata : best_dl_reg;
    assign n_inc   = n_reg + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        cmd_next         = cmd_reg;
        armed_next       = armed_reg;
        pending_next     = pending_reg;
        handle_time_next = handle_time_reg;
        idx_next         = idx_reg;
        iss_done_next    = iss_done_reg;
        chk_valid_next   = chk_valid_reg;
        chk_idx_next     = chk_idx_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_dl_next     = best_dl_reg;
        held_valid_next  = held_valid_reg;
        held_idx_next    = held_idx_reg;
        n_next           = n_reg;
        res_ok_next      = res_ok_reg;
        res_slot_next    = res_slot_reg;
        res_last_next    = res_last_reg;
        out_valid_next   = out_valid_reg;
        out_ok_next      = out_ok_reg;
        out_slot_next    = out_slot_reg;
        out_last_next    = out_last_reg;
        dl_we            = 1'b0;
        dl_waddr         = idx_reg;
        dl_wdata         = cmd_reg.now_us + {1'b0, cmd_reg.period_us};
        pr_we            = 1'b0;

        if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_next = pop_data;
                    ret_next = S_IDLE;
                    unique case (pop_data.kind)
                        KIND_ADD:
                        begin
                            idx_next   = '0;
                            state_next = S_ADD_SCAN;
                        end
                        KIND_HANDLE:
                        begin
                            handle_time_next = pop_data.now_us;
                            n_next           = '0;
                            held_valid_next  = 1'b0;
                            idx_next         = '0;
                            iss_done_next    = 1'b0;
                            chk_valid_next   = 1'b0;
                            best_found_next  = 1'b0;
                            state_next       = S_HND_SCAN;
                        end
                        KIND_REPORT:
                        begin
                            res_slot_next = pop_data.slot;
                            res_last_next = 1'b1;
                            if (pop_data.slot_in_range && pending_reg[pop_idx])
                            begin
                                pending_next[pop_idx] = 1'b0;
                                res_ok_next           = 1'b1;
                                state_next = pop_data.keep ? S_REP_READ : S_POST;
                            end
                            else
                            begin
                                res_ok_next = 1'b0;
                                state_next  = S_POST;
                            end
                        end
                        KIND_NONE:
                        begin
                            res_ok_next   = 1'b0;
                            res_slot_next = '0;
                            res_last_next = 1'b1;
                            state_next    = S_POST;
                        end
                    endcase
                end
            end

            S_ADD_SCAN:
            begin
                ret_next = S_IDLE;
                if (!armed_reg[idx_reg] && !pending_reg[idx_reg])
                begin
                    dl_we               = 1'b1;
                    pr_we               = 1'b1;
                    armed_next[idx_reg] = 1'b1;
                    res_ok_next         = 1'b1;
                    res_slot_next       = slot_code(idx_reg);
                    res_last_next       = 1'b1;
                    state_next          = S_POST;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_ok_next   = 1'b0;
                    res_slot_next = '0;
                    res_last_next = 1'b1;
                    state_next    = S_POST;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_HND_SCAN:
            begin
                // read issue runs ahead of the compare, which sees each read in the next cycle
                chk_valid_next  = !iss_done_reg;
                chk_idx_next    = idx_reg;
                if (!iss_done_reg)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                best_found_next = f_found;
                best_idx_next   = f_idx;
                best_dl_next    = f_dl;

                if (chk_valid_reg && chk_idx_reg == LAST_IDX)
                begin
                    // pass done; next pass starts from a clean scan
                    idx_next        = '0;
                    iss_done_next   = 1'b0;
                    chk_valid_next  = 1'b0;
                    best_found_next = 1'b0;
                    if (f_found)
                    begin
                        armed_next[f_idx]   = 1'b0;
                        pending_next[f_idx] = 1'b1;
                        n_next              = n_inc;
                        held_valid_next     = 1'b1;
                        held_idx_next       = f_idx;
                        ret_next = (n_inc == NCNT_W'(MAX_OUT)) ? S_HND_FLUSH : S_HND_SCAN;
                        if (held_valid_reg)
                        begin
                            res_ok_next   = 1'b1;
                            res_slot_next = slot_code(held_idx_reg);
                            res_last_next = 1'b0;
                            state_next    = S_POST;
                        end
                        else if (n_inc == NCNT_W'(MAX_OUT))
                        begin
                            state_next = S_HND_FLUSH;
                        end
                    end
                    else if (held_valid_reg)
                    begin
                        state_next = S_HND_FLUSH;
                    end
                    else
                    begin
                        res_ok_next   = 1'b0;
                        res_slot_next = '0;
                        res_last_next = 1'b1;
                        ret_next      = S_IDLE;
                        state_next    = S_POST;
                    end
                end
            end

            S_HND_FLUSH:
            begin
                res_ok_next   = 1'b1;
                res_slot_next = slot_code(held_idx_reg);
                res_last_next = 1'b1;
                ret_next      = S_IDLE;
                state_next    = S_POST;
            end

            S_REP_READ:
            begin
                dl_we               = 1'b1;
                dl_waddr            = rep_idx;
                dl_wdata            = handle_time_reg + {1'b0, pr_rdata};
                armed_next[rep_idx] = 1'b1;
                ret_next            = S_IDLE;
                state_next          = S_POST;
            end

            S_POST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_slot_next  = res_slot_reg;
                    out_last_next  = res_last_reg;
                    state_next     = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ret_reg         <= S_IDLE;
            cmd_reg         <= '0;
            armed_reg       <= '0;
            pending_reg     <= '0;
            handle_time_reg <= '0;
            idx_reg         <= '0;
            iss_done_reg    <= 1'b0;
            chk_valid_reg   <= 1'b0;
            chk_idx_reg     <= '0;
            best_found_reg  <= 1'b0;
            best_idx_reg    <= '0;
            best_dl_reg     <= '0;
            held_valid_reg  <= 1'b0;
            held_idx_reg    <= '0;
            n_reg           <= '0;
            res_ok_reg      <= 1'b0;
            res_slot_reg    <= '0;
            res_last_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_ok_reg      <= 1'b0;
            out_slot_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            cmd_reg         <= cmd_next;
            armed_reg       <= armed_next;
            pending_reg     <= pending_next;
            handle_time_reg <= handle_time_next;
            idx_reg         <= idx_next;
            iss_done_reg    <= iss_done_next;
            chk_valid_reg   <= chk_valid_next;
            chk_idx_reg     <= chk_idx_next;
            best_found_reg  <= best_found_next;
            best_idx_reg    <= best_idx_next;
            best_dl_reg     <= best_dl_next;
            held_valid_reg  <= held_valid_next;
            held_idx_reg    <= held_idx_next;
            n_reg           <= n_next;
            res_ok_reg      <= res_ok_next;
            res_slot_reg    <= res_slot_next;
            res_last_reg    <= res_last_next;
            out_valid_reg   <= out_valid_next;
            out_ok_reg      <= out_ok_next;
            out_slot_reg    <= out_slot_next;
            out_last_reg    <= out_last_next;
        end
    end

endmodule

// ===== rtl/periodic_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_tick_scheduler: table of periodic tick slots
// Adds ticks, reports due ticks in deadline order and re-arms or frees them.
//
//   channel  dir  handshake    payload
//   cmd      in   valid/ready  op, period_ms, now_us, slot, keep
//   evt      out  valid/ready  ok, slot_out, last
//
// Commands pass the front stage register, then a queue entry, to the engine.
// Add: a free-slot scan tries slots in index order, up to SLOTS of them.
// Handle: earliest-deadline passes through the single deadline RAM read port,
// one pass per due slot plus a final empty pass, which is skipped once
// MAX_OUT slots have come out. Reset clears all slot bits; no clearing pass.
// Either side may stall; cmd is taken until front stage and queue are full.
// ----------------------------------------------------------------------------
module periodic_tick_scheduler (
    input  logic  clk,
    input  logic  rst_n,
    pts_cmd_if.sink   cmd,
    pts_evt_if.source evt
);
    import pts_pkg::*;

    logic  push_valid;
    logic  push_ready;
    cmd_t  push_data;
    logic  pop_valid;
    logic  pop_ready;
    cmd_t  pop_data;

    pts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pts_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .evt       (evt)
    );

endmodule
